// ===== hw/rtl/hvn_pkg.sv =====
`timescale 1ns / 1ps

package hvn_pkg;

   localparam int REG_BITS = 16;
   localparam int NRM_BITS = 16;
   localparam int ONE_Q14 = 16384;
   localparam int CSR_IDX_BITS = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_TERRAIN_HEIGHT = 2'd0,
      CSR_CELL_SIZE_X    = 2'd1,
      CSR_CELL_SIZE_Z    = 2'd2
   } csr_idx_type;

   // Result of one normalize unit: signed Q1.14 components.
   typedef struct packed {
      logic signed [NRM_BITS-1:0] x;
      logic signed [NRM_BITS-1:0] y;
      logic signed [NRM_BITS-1:0] z;
   } vec_type;

endpackage

// ===== hw/rtl/hvn_stream_if.sv =====
`timescale 1ns / 1ps

interface hvn_stream_if #(
   parameter int WIDTH = 8
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hvn_isqrt.sv =====
`timescale 1ns / 1ps

// Pipelined integer square root, one result bit per stage, with sideband data.
// Values enter each cycle while enabled; there are OUT_BITS stages, and enable stalls all stages.
module hvn_isqrt #(
   parameter int IN_BITS  = 64,
   parameter int SIDE_BITS = 8
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic [IN_BITS-1:0]       val_in,
   input  logic [SIDE_BITS-1:0]     side_in,
   output logic [IN_BITS/2-1:0]     root_out,
   output logic [SIDE_BITS-1:0]     side_out
);
   localparam int OUT_BITS = IN_BITS / 2;

   logic [IN_BITS-1:0]   rem_ff  [OUT_BITS+1];
   logic [OUT_BITS-1:0]  root_ff [OUT_BITS+1];
   logic [SIDE_BITS-1:0] side_ff [OUT_BITS+1];

   always_comb begin
      rem_ff[0]  = val_in;
      root_ff[0] = '0;
      side_ff[0] = side_in;
   end

   for (genvar k = 0; k < OUT_BITS; k++) begin : g_stage
      localparam int B = OUT_BITS - 1 - k;
      logic [IN_BITS-1:0]  trial_in;
      logic [IN_BITS-1:0]  sq_in;
      always_comb begin
         // trial = (2*root*2^B + 2^(2B))
         trial_in = ({{(IN_BITS-OUT_BITS){1'b0}}, root_ff[k]} << (B + 1))
            | ({{(IN_BITS-1){1'b0}}, 1'b1} << (2 * B));
         sq_in = rem_ff[k] - trial_in;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            side_ff[k+1] <= side_ff[k];
            if (rem_ff[k] >= trial_in) begin
               rem_ff[k+1]  <= sq_in;
               root_ff[k+1] <= root_ff[k] | (OUT_BITS'(1) << B);
            end else begin
               rem_ff[k+1]  <= rem_ff[k];
               root_ff[k+1] <= root_ff[k];
            end
         end
      end
   end

   assign root_out = root_ff[OUT_BITS];
   assign side_out = side_ff[OUT_BITS];
endmodule

// ===== hw/rtl/hvn_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// quo = num / den; den must be nonzero when the result is used.
module hvn_div #(
   parameter int NUM_BITS  = 46,
   parameter int DEN_BITS  = 34,
   parameter int SIDE_BITS = 8
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic [NUM_BITS-1:0]    num_in,
   input  logic [DEN_BITS-1:0]    den_in,
   input  logic [SIDE_BITS-1:0]   side_in,
   output logic [NUM_BITS-1:0]    quo_out,
   output logic [SIDE_BITS-1:0]   side_out
);
   localparam int RW = DEN_BITS + 1;

   logic [RW-1:0]        rem_ff  [NUM_BITS+1];
   logic [NUM_BITS-1:0]  num_ff  [NUM_BITS+1];
   logic [DEN_BITS-1:0]  den_ff  [NUM_BITS+1];
   logic [SIDE_BITS-1:0] side_ff [NUM_BITS+1];

   always_comb begin
      rem_ff[0]  = '0;
      num_ff[0]  = num_in;
      den_ff[0]  = den_in;
      side_ff[0] = side_in;
   end

   for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
      logic [RW-1:0] sh_in;
      always_comb begin
         sh_in = {rem_ff[k][RW-2:0], num_ff[k][NUM_BITS-1]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
            if (sh_in >= {1'b0, den_ff[k]}) begin
               rem_ff[k+1] <= sh_in - {1'b0, den_ff[k]};
               num_ff[k+1] <= {num_ff[k][NUM_BITS-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= sh_in;
               num_ff[k+1] <= {num_ff[k][NUM_BITS-2:0], 1'b0};
            end
         end
      end
   end

   // after all shifts the quotient bits have replaced the numerator
   assign quo_out  = num_ff[NUM_BITS];
   assign side_out = side_ff[NUM_BITS];
endmodule

// ===== hw/rtl/hvn_normalize.sv =====
`timescale 1ns / 1ps

// Pipelined 3-vector normalize to Q1.14. Components are signed, |c| <= 2^16.
// Stages: magnitudes, sum of squares, square root, dividers, output register.
module hvn_normalize #(
   parameter int SIDE_BITS = 8
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic signed [17:0]     cx_in,
   input  logic signed [17:0]     cy_in,
   input  logic signed [17:0]     cz_in,
   input  logic [SIDE_BITS-1:0]   side_in,
   output hvn_pkg::vec_type       vec_out,
   output logic                   zero_out,
   output logic [SIDE_BITS-1:0]   side_out
);
   import hvn_pkg::*;

   localparam int MAG_BITS = 17;
   localparam int Q_BITS   = 36;
   localparam int SQ_IN    = 64;
   localparam int LEN_BITS = SQ_IN / 2;
   localparam int NUM_BITS = MAG_BITS + 28 + 1;
   localparam int SB1 = 1 + 3 + 3 * MAG_BITS + SIDE_BITS;

   // stage 1: magnitudes and signs
   logic [MAG_BITS-1:0] mag_ff [3];
   logic [2:0]          neg_ff;
   logic [SIDE_BITS-1:0] s1_side_ff;
   // stage 2: sum of squares
   logic [Q_BITS-1:0]   q_ff;
   logic [MAG_BITS-1:0] m2_ff [3];
   logic [2:0]          n2_ff;
   logic [SIDE_BITS-1:0] s2_side_ff;
   logic [MAG_BITS-1:0] mag_in [3];
   logic [Q_BITS-1:0]   q_in;

   always_comb begin
      mag_in[0] = MAG_BITS'(cx_in < 0 ? -cx_in : cx_in);
      mag_in[1] = MAG_BITS'(cy_in < 0 ? -cy_in : cy_in);
      mag_in[2] = MAG_BITS'(cz_in < 0 ? -cz_in : cz_in);
      q_in = Q_BITS'(mag_ff[0]) * Q_BITS'(mag_ff[0])
         + Q_BITS'(mag_ff[1]) * Q_BITS'(mag_ff[1])
         + Q_BITS'(mag_ff[2]) * Q_BITS'(mag_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= mag_in[i];
            m2_ff[i]  <= mag_ff[i];
         end
         neg_ff     <= {cz_in < 0, cy_in < 0, cx_in < 0};
         s1_side_ff <= side_in;
         q_ff       <= q_in;
         n2_ff      <= neg_ff;
         s2_side_ff <= s1_side_ff;
      end
   end

   logic [LEN_BITS-1:0] len_w;
   logic [SB1-1:0]      sq_side_w;

   hvn_isqrt #(.IN_BITS(SQ_IN), .SIDE_BITS(SB1)) u_sqrt (
      .clock    (clock),
      .enable   (enable),
      .val_in   ({q_ff[SQ_IN-29:0], 28'd0}),
      .side_in  ({(q_ff == '0), n2_ff[2:1], n2_ff[0], m2_ff[2], m2_ff[1], m2_ff[0],
                  s2_side_ff}),
      .root_out (len_w),
      .side_out (sq_side_w)
   );

   // the root of q * 2^28 with q < 2^35 fits 32 bits
   logic                 zero_w;
   logic [2:0]           neg_w;
   logic [MAG_BITS-1:0]  m_w [3];
   logic [SIDE_BITS-1:0] side_w;
   assign {zero_w, neg_w, m_w[2], m_w[1], m_w[0], side_w} = sq_side_w;

   localparam int SB2 = 1 + 3 + SIDE_BITS;
   logic [NUM_BITS-1:0] quo_w [3];
   logic [SB2-1:0]      dside_w [3];
   logic [LEN_BITS-1:0] den_w;
   assign den_w = zero_w ? LEN_BITS'(1) : len_w;

   for (genvar c = 0; c < 3; c++) begin : g_div
      logic [NUM_BITS-1:0] num_w;
      assign num_w = ({{(NUM_BITS-MAG_BITS){1'b0}}, m_w[c]} << 28)
         + NUM_BITS'(len_w >> 1);
      hvn_div #(.NUM_BITS(NUM_BITS), .DEN_BITS(LEN_BITS), .SIDE_BITS(SB2)) u_div (
         .clock    (clock),
         .enable   (enable),
         .num_in   (num_w),
         .den_in   (den_w),
         .side_in  ({zero_w, neg_w, side_w}),
         .quo_out  (quo_w[c]),
         .side_out (dside_w[c])
      );
   end

   logic [NRM_BITS-1:0] comp_in [3];
   logic                zero_d;
   logic [2:0]          neg_d;
   always_comb begin
      {zero_d, neg_d} = dside_w[0][SB2-1:SIDE_BITS];
      for (int i = 0; i < 3; i++) begin
         comp_in[i] = (quo_w[i] > NUM_BITS'(ONE_Q14)) ? NRM_BITS'(ONE_Q14)
            : quo_w[i][NRM_BITS-1:0];
         if (zero_d) comp_in[i] = '0;
         else if (neg_d[i]) comp_in[i] = -comp_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vec_out.x <= comp_in[0];
         vec_out.y <= comp_in[1];
         vec_out.z <= comp_in[2];
         zero_out  <= zero_d;
         side_out  <= dside_w[0][SIDE_BITS-1:0];
      end
   end
endmodule

// ===== hw/rtl/heightmap_vertex_normal_core.sv =====
`timescale 1ns / 1ps

// Heightmap vertex and normal core. Takes one request per cycle and returns
// one response per request, in order. The path is a pipeline: height
// scaling (3 stages), four parallel term normalizers, a summing stage and a
// final normalizer; each normalizer is 2 input stages, a 32-stage square
// root, 46-stage dividers and an output stage, and the core output register
// comes last. A stalled output freezes the whole pipeline; the request side
// stays ready whenever the output stage is empty or being taken, so
// throughput is one request per cycle. After reset the response valid is held
// low while the pipeline flushes. Configuration takes effect on requests
// accepted after the write.
module heightmap_vertex_normal_core #(
   parameter int SAMPLE_BITS = 8,
   parameter int COORD_BITS  = 12
) (
   input  logic clock,
   input  logic reset,
   hvn_stream_if.sink   req,
   hvn_stream_if.source rsp,
   input  logic                        csr_write,
   input  logic [hvn_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [hvn_pkg::REG_BITS-1:0]     csr_data
);
   import hvn_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int POS_BITS = 16 + COORD_BITS;
   localparam int SMAX = (1 << SB) - 1;
   localparam int PROD_BITS = SB + 16;
   // reciprocal: floor(x / SMAX) = (x * RECIP) >> SHIFT for x < 2^PROD_BITS
   localparam int SHIFT = PROD_BITS + SB + 1;
   localparam longint RECIP = ((64'd1 << SHIFT) + SMAX - 1) / SMAX;
   localparam int RW = SB + 2;
   // cycles until the side chain of the last normalizer holds reset-time data
   localparam int FLUSH_CYCLES = 163;

   // request fields layout (LSB first): center, west, north, east, south,
   // inside flags w n e s, map_x, map_y
   logic [SB-1:0] h_w [5];
   logic [3:0]    in_w;
   logic [COORD_BITS-1:0] mx_w, my_w;
   assign h_w[0] = req.data[SB-1:0];
   assign h_w[1] = req.data[2*SB-1:SB];
   assign h_w[2] = req.data[3*SB-1:2*SB];
   assign h_w[3] = req.data[4*SB-1:3*SB];
   assign h_w[4] = req.data[5*SB-1:4*SB];
   assign in_w   = req.data[5*SB+3:5*SB];
   assign mx_w   = req.data[5*SB+4+COORD_BITS-1:5*SB+4];
   assign my_w   = req.data[5*SB+4+2*COORD_BITS-1:5*SB+4+COORD_BITS];

   logic [15:0] th_ff, cx_ff, cz_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         th_ff <= 16'd256;
         cx_ff <= 16'd256;
         cz_ff <= 16'd256;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_index))
            CSR_TERRAIN_HEIGHT: th_ff <= csr_data;
            CSR_CELL_SIZE_X:    cx_ff <= csr_data;
            CSR_CELL_SIZE_Z:    cz_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic enable;
   logic out_valid_ff;
   assign enable    = !out_valid_ff || rsp.ready;
   assign req.ready = enable;

   // stage A: products
   logic                 a_vld_ff;
   logic [PROD_BITS-1:0] a_prod_ff [5];
   logic [3:0]           a_in_ff;
   logic [POS_BITS-1:0]  a_px_ff, a_pz_ff;
   logic [15:0]          a_cx_ff, a_cz_ff;
   // stage B: times reciprocal
   logic                 b_vld_ff;
   logic [PROD_BITS+SHIFT-1:0] b_q_ff [5];
   logic [3:0]           b_in_ff;
   logic [POS_BITS-1:0]  b_px_ff, b_pz_ff;
   logic [15:0]          b_cx_ff, b_cz_ff;
   // stage C: heights
   logic                 c_vld_ff;
   logic [15:0]          c_h_ff [5];
   logic [3:0]           c_in_ff;
   logic [POS_BITS-1:0]  c_px_ff, c_pz_ff;
   logic [15:0]          c_cx_ff, c_cz_ff;

   logic [PROD_BITS-1:0] prod_in [5];
   logic [15:0]          h_in [5];
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         prod_in[i] = PROD_BITS'(h_w[i]) * PROD_BITS'(th_ff) + PROD_BITS'(SMAX >> 1);
         h_in[i] = 16'(b_q_ff[i] >> SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (enable) begin
         a_vld_ff <= req.valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 5; i++) begin
            a_prod_ff[i] <= prod_in[i];
            b_q_ff[i] <= (PROD_BITS+SHIFT)'(a_prod_ff[i])
               * (PROD_BITS+SHIFT)'(RECIP);
            c_h_ff[i] <= h_in[i];
         end
         a_in_ff <= in_w;
         a_px_ff <= POS_BITS'(cx_ff) * POS_BITS'(mx_w);
         a_pz_ff <= POS_BITS'(cz_ff) * POS_BITS'(my_w);
         a_cx_ff <= cx_ff;
         a_cz_ff <= cz_ff;
         b_in_ff <= a_in_ff; b_px_ff <= a_px_ff; b_pz_ff <= a_pz_ff;
         b_cx_ff <= a_cx_ff; b_cz_ff <= a_cz_ff;
         c_in_ff <= b_in_ff; c_px_ff <= b_px_ff; c_pz_ff <= b_pz_ff;
         c_cx_ff <= b_cx_ff; c_cz_ff <= b_cz_ff;
      end
   end

   // differences (west, north, east, south)
   logic signed [17:0] d_w [4];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         d_w[i] = c_in_ff[i] ? (18'(c_h_ff[i+1]) - 18'(c_h_ff[0])) : '0;
      end
   end

   localparam int SIDE1 = 1 + 2 * POS_BITS + 16;
   logic [SIDE1-1:0] side1_in;
   assign side1_in = {c_vld_ff, c_px_ff, c_pz_ff, c_h_ff[0]};

   vec_type          t_vec [4];
   logic             t_zero [4];
   logic [SIDE1-1:0] t_side [4];

   hvn_normalize #(.SIDE_BITS(SIDE1)) u_nw (
      .clock(clock), .enable(enable), .cx_in(d_w[0]), .cy_in(18'(c_cx_ff)),
      .cz_in(18'sd0), .side_in(side1_in), .vec_out(t_vec[0]), .zero_out(t_zero[0]),
      .side_out(t_side[0]));
   hvn_normalize #(.SIDE_BITS(SIDE1)) u_ne (
      .clock(clock), .enable(enable), .cx_in(-d_w[2]), .cy_in(18'(c_cx_ff)),
      .cz_in(18'sd0), .side_in(side1_in), .vec_out(t_vec[1]), .zero_out(t_zero[1]),
      .side_out(t_side[1]));
   hvn_normalize #(.SIDE_BITS(SIDE1)) u_nn (
      .clock(clock), .enable(enable), .cx_in(18'sd0), .cy_in(18'(c_cz_ff)),
      .cz_in(d_w[1]), .side_in(side1_in), .vec_out(t_vec[2]), .zero_out(t_zero[2]),
      .side_out(t_side[2]));
   hvn_normalize #(.SIDE_BITS(SIDE1)) u_ns (
      .clock(clock), .enable(enable), .cx_in(18'sd0), .cy_in(18'(c_cz_ff)),
      .cz_in(-d_w[3]), .side_in(side1_in), .vec_out(t_vec[3]), .zero_out(t_zero[3]),
      .side_out(t_side[3]));

   // sum stage; zero terms already come out as zero vectors
   logic signed [17:0] s_x_ff, s_y_ff, s_z_ff;
   logic [SIDE1-1:0]   s_side_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         s_x_ff <= 18'(t_vec[0].x) + 18'(t_vec[1].x) + 18'(t_vec[2].x) + 18'(t_vec[3].x);
         s_y_ff <= 18'(t_vec[0].y) + 18'(t_vec[1].y) + 18'(t_vec[2].y) + 18'(t_vec[3].y);
         s_z_ff <= 18'(t_vec[0].z) + 18'(t_vec[1].z) + 18'(t_vec[2].z) + 18'(t_vec[3].z);
         s_side_ff <= t_side[0];
      end
   end

   vec_type          f_vec;
   logic             f_zero;
   logic [SIDE1-1:0] f_side;
   hvn_normalize #(.SIDE_BITS(SIDE1)) u_nf (
      .clock(clock), .enable(enable), .cx_in(s_x_ff), .cy_in(s_y_ff),
      .cz_in(s_z_ff), .side_in(s_side_ff), .vec_out(f_vec), .zero_out(f_zero),
      .side_out(f_side));

   logic                f_vld;
   logic [POS_BITS-1:0] f_px, f_pz;
   logic [15:0]         f_h;
   assign {f_vld, f_px, f_pz, f_h} = f_side;

   // valid bits inside the normalizers carry no reset; mask them until flushed
   logic [7:0] flush_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         flush_ff <= '0;
      end else if (flush_ff != 8'(FLUSH_CYCLES)) begin
         flush_ff <= flush_ff + 8'd1;
      end
   end

   logic [2*POS_BITS+16+3*NRM_BITS-1:0] out_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= (flush_ff == 8'(FLUSH_CYCLES)) && f_vld;
      end
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         out_data_ff <= {f_zero ? NRM_BITS'(0) : f_vec.z,
                         f_zero ? NRM_BITS'(ONE_Q14) : f_vec.y,
                         f_zero ? NRM_BITS'(0) : f_vec.x,
                         f_pz, f_h, f_px};
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_data_ff;

   // unused term flags
   logic unused_ok;
   assign unused_ok = t_zero[0] ^ t_zero[1] ^ t_zero[2] ^ t_zero[3];
   logic unused_sink;
   always_ff @(posedge clock) unused_sink <= unused_ok;
endmodule

// ===== hw/rtl/hvn_checker.sv =====
`timescale 1ns / 1ps

module hvn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [119:0] rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind heightmap_vertex_normal_core hvn_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import hvn_pkg::*;

   localparam int REQ_W = 68;
   localparam int RSP_W = 120;
   localparam int SETTLE = 250;
   localparam int LIMIT = 400000;

   typedef struct packed {
      logic [7:0]  h_c;
      logic [7:0]  h_w;
      logic [7:0]  h_n;
      logic [7:0]  h_e;
      logic [7:0]  h_s;
      logic        in_w;
      logic        in_n;
      logic        in_e;
      logic        in_s;
      logic [11:0] map_x;
      logic [11:0] map_y;
   } sample_type;

   typedef struct packed {
      logic [27:0]        pos_x;
      logic [15:0]        pos_h;
      logic [27:0]        pos_z;
      logic signed [15:0] n_x;
      logic signed [15:0] n_y;
      logic signed [15:0] n_z;
   } vertex_type;

   typedef struct {
      sample_type s;
      bit         fixed;
      vertex_type v;
   } dir_row_type;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   localparam vertex_type UP0 = '{28'd0, 16'd0, 28'd0, 16'sd0, 16'sd16384, 16'sd0};
   localparam vertex_type UPMAX = '{28'd1048320, 16'd256, 28'd1048320,
                                   16'sd0, 16'sd16384, 16'sd0};
   localparam vertex_type UPFLAT = '{28'd0, 16'd256, 28'd0, 16'sd0, 16'sd16384, 16'sd0};

   dir_row_type dir_tab[14] = '{
      '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1, 12'd0, 12'd0}, 1'b1, UP0},
      '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1,
          12'd4095, 12'd4095}, 1'b1, UPMAX},
      '{'{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0},
          1'b1, UPFLAT},
      '{'{8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1,
          12'h555, 12'hAAA}, 1'b0, UP0},
      '{'{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1,
          12'hAAA, 12'h555}, 1'b0, UP0},
      '{'{8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 12'd1, 12'd0}, 1'b0, UP0},
      '{'{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0, 12'd0, 12'd1}, 1'b0, UP0},
      '{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 12'd7, 12'd9}, 1'b0, UP0},
      '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b1, 12'd9, 12'd7}, 1'b0, UP0},
      '{'{8'd128, 8'd255, 8'd1, 8'd255, 8'd1, 1'b1, 1'b1, 1'b1, 1'b1, 12'd5, 12'd6}, 1'b0, UP0},
      '{'{8'd128, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1, 12'd3, 12'd3}, 1'b0, UP0},
      '{'{8'd1, 8'd2, 8'd0, 8'd254, 8'd3, 1'b1, 1'b0, 1'b1, 1'b0, 12'd100, 12'd200},
          1'b0, UP0},
      '{'{8'd200, 8'd10, 8'd250, 8'd60, 8'd199, 1'b0, 1'b1, 1'b0, 1'b1,
          12'd4000, 12'd17}, 1'b0, UP0},
      '{'{8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 1'b1, 1'b1, 1'b1, 1'b1, 12'd4095, 12'd0},
          1'b0, UP0}
   };

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [REG_BITS-1:0] csr_data;

   hvn_stream_if #(.WIDTH(REQ_W)) req_if ();
   hvn_stream_if #(.WIDTH(RSP_W)) rsp_if ();

   heightmap_vertex_normal_core uut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // shadow copy of the configuration
   longint unsigned terrain_h = 256;
   longint unsigned cell_x = 256;
   longint unsigned cell_z = 256;

   vertex_type pending_vertices[$];
   int error_count = 0;
   int cycle_count = 0;
   idle_mode_type idle_mode = IDLE_NONE;
   bit hold_req = 0;
   logic hold_active = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic void unit_vec(input longint c[3], output longint o[3]);
      longint unsigned q = 0;
      longint unsigned len;
      longint unsigned m;
      longint unsigned a[3];
      for (int i = 0; i < 3; i++) begin
         a[i] = c[i] < 0 ? -c[i] : c[i];
         q += a[i] * a[i];
      end
      if (q == 0) begin
         o = '{0, 0, 0};
         return;
      end
      len = sqrt_floor(q << 28);
      for (int i = 0; i < 3; i++) begin
         m = ((a[i] << 28) + (len >> 1)) / len;
         if (m > ONE_Q14) m = ONE_Q14;
         o[i] = c[i] < 0 ? -longint'(m) : longint'(m);
      end
   endfunction

   function automatic longint scale_height(logic [7:0] s);
      return longint'((terrain_h * s + 127) / 255);
   endfunction

   // request layout on the bus: center in the low byte, map_y on top
   function automatic logic [REQ_W-1:0] req_bits(sample_type s);
      return {s.map_y, s.map_x, s.in_s, s.in_e, s.in_n, s.in_w,
              s.h_s, s.h_e, s.h_n, s.h_w, s.h_c};
   endfunction

   // response layout on the bus: pos_x in the low bits, normal_z on top
   function automatic vertex_type rsp_vertex(logic [RSP_W-1:0] d);
      vertex_type v;
      v.pos_x = d[27:0];
      v.pos_h = d[43:28];
      v.pos_z = d[71:44];
      v.n_x = d[87:72];
      v.n_y = d[103:88];
      v.n_z = d[119:104];
      return v;
   endfunction

   function automatic vertex_type vertex_of(sample_type s);
      vertex_type v;
      longint hc;
      longint dw, dn, de, ds;
      longint t[3];
      longint u[3];
      longint acc[3];
      longint nrm[3];
      hc = scale_height(s.h_c);
      dw = s.in_w ? scale_height(s.h_w) - hc : 0;
      dn = s.in_n ? scale_height(s.h_n) - hc : 0;
      de = s.in_e ? scale_height(s.h_e) - hc : 0;
      ds = s.in_s ? scale_height(s.h_s) - hc : 0;
      acc = '{0, 0, 0};
      for (int k = 0; k < 4; k++) begin
         case (k)
            0: t = '{dw, longint'(cell_x), 0};
            1: t = '{-de, longint'(cell_x), 0};
            2: t = '{0, longint'(cell_z), dn};
            default: t = '{0, longint'(cell_z), -ds};
         endcase
         unit_vec(t, u);
         for (int j = 0; j < 3; j++) acc[j] += u[j];
      end
      if (acc[0] == 0 && acc[1] == 0 && acc[2] == 0) nrm = '{0, ONE_Q14, 0};
      else unit_vec(acc, nrm);
      v.pos_x = 28'(cell_x * s.map_x);
      v.pos_h = 16'(hc);
      v.pos_z = 28'(cell_z * s.map_y);
      v.n_x = 16'(nrm[0]);
      v.n_y = 16'(nrm[1]);
      v.n_z = 16'(nrm[2]);
      return v;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_vertex(vertex_type got);
      vertex_type want;
      if (pending_vertices.size() == 0) begin
         report_mismatch("unexpected response, pos_x", got.pos_x, -1);
         return;
      end
      want = pending_vertices.pop_front();
      if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
      if (got.pos_h !== want.pos_h) report_mismatch("pos_height", got.pos_h, want.pos_h);
      if (got.pos_z !== want.pos_z) report_mismatch("pos_z", got.pos_z, want.pos_z);
      if (got.n_x !== want.n_x) report_mismatch("normal_x", got.n_x, want.n_x);
      if (got.n_y !== want.n_y) report_mismatch("normal_y", got.n_y, want.n_y);
      if (got.n_z !== want.n_z) report_mismatch("normal_z", got.n_z, want.n_z);
   endtask

   // response side
   initial begin
      rsp_if.ready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) check_vertex(rsp_vertex(rsp_if.data));
         if (hold_active)
            rsp_if.ready <= 0;
         else if (idle_mode == IDLE_RECV)
            rsp_if.ready <= $urandom_range(99) >= 57;
         else if (idle_mode == IDLE_BOTH)
            rsp_if.ready <= $urandom_range(99) >= 13;
         else
            rsp_if.ready <= 1;
      end
   end

   // long back-pressure so the pipeline fills and the request side stalls
   initial begin
      forever begin
         wait (hold_req);
         hold_active <= 1;
         repeat (600) @(posedge clock);
         hold_active <= 0;
         hold_req = 0;
      end
   end

   task automatic send_request(sample_type s, bit fixed, vertex_type fixed_v);
      int gap_pct;
      gap_pct = idle_mode == IDLE_SEND ? 57 : (idle_mode == IDLE_BOTH ? 13 : 0);
      while ($urandom_range(99) < gap_pct) begin
         req_if.valid <= 0;
         @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.data <= req_bits(s);
      do @(posedge clock); while (!req_if.ready);
      pending_vertices.push_back(fixed ? fixed_v : vertex_of(s));
   endtask

   function automatic sample_type random_sample();
      sample_type s;
      s = sample_type'(REQ_W'({$urandom, $urandom, $urandom}));
      case ($urandom_range(9))
         0: s.map_x = 12'hFFF;
         1: s.map_y = 12'hFFF;
         2: begin
            s.h_w = s.h_c;
            s.h_e = s.h_c;
         end
         3: s.h_c = $urandom_range(1) ? 8'hFF : 8'h00;
         default: ;
      endcase
      return s;
   endfunction

   task automatic write_reg(csr_idx_type idx, logic [15:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      @(posedge clock);
      case (idx)
         CSR_TERRAIN_HEIGHT: terrain_h = val;
         CSR_CELL_SIZE_X: cell_x = val;
         default: cell_z = val;
      endcase
   endtask

   initial begin
      logic [15:0] cfg_h [8];
      logic [15:0] cfg_x [8];
      logic [15:0] cfg_z [8];
      idle_mode_type modes [8];
      cfg_h = '{16'd256, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
      cfg_x = '{16'd256, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0};
      cfg_z = '{16'd256, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0};
      modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
      for (int p = 5; p < 8; p++) begin
         cfg_h[p] = $urandom_range(65535);
         cfg_x[p] = $urandom_range(65535);
         cfg_z[p] = $urandom_range(65535);
      end

      reset = 1;
      csr_write = 0;
      csr_index = CSR_TERRAIN_HEIGHT;
      csr_data = '0;
      req_if.valid = 0;
      req_if.data = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int p = 0; p < 8; p++) begin
         if (p > 0) begin
            req_if.valid <= 0;
            wait (pending_vertices.size() == 0);
            repeat (SETTLE) @(posedge clock);
            write_reg(CSR_TERRAIN_HEIGHT, cfg_h[p]);
            write_reg(CSR_CELL_SIZE_X, cfg_x[p]);
            write_reg(CSR_CELL_SIZE_Z, cfg_z[p]);
         end
         idle_mode = modes[p];
         if (p == 0)
            foreach (dir_tab[i]) send_request(dir_tab[i].s, dir_tab[i].fixed, dir_tab[i].v);
         if (p == 4) hold_req = 1;
         for (int n = 0; n < (p == 4 ? 300 : 35); n++)
            send_request(random_sample(), 1'b0, UP0);
      end
      req_if.valid <= 0;
      idle_mode = IDLE_NONE;
      wait (pending_vertices.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
